// ===== rtl/core/motor_speed_incremental_pid_defines.svh =====
// Assertion macros for the motor speed incremental PID block.
// Used by rtl/core/motor_speed_incremental_pid.sv; needs no other file.
`ifndef MOTOR_SPEED_INCREMENTAL_PID_DEFINES_SVH
`define MOTOR_SPEED_INCREMENTAL_PID_DEFINES_SVH

`ifndef SYNTHESIS
// explicit clock and reset
`define MSIPID_ASSERT_CLK(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
    else $error("%m: check failed");
// module clock clk, active-low reset rst_n
`define MSIPID_ASSERT(lbl, prop) \
  `MSIPID_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define MSIPID_ASSERT_CLK(lbl, clk_sig, rst_sig, prop)
`define MSIPID_ASSERT(lbl, prop)
`endif

`endif

// ===== rtl/core/msipid_pkg.sv =====
// Package for the motor speed incremental PID block: widths, register
// indexes, reset values and the sequencer state type. No dependencies.
package msipid_pkg;

  localparam int SPEED_W    = 16;  // Q11.4 speed
  localparam int ERR_W      = 17;  // target - filtered
  localparam int ERR_ST_W   = 18;  // stored error history
  localparam int D1_W       = 19;  // e - e1
  localparam int OPA_W      = 16;  // multiplier operand A (gains, weights)
  localparam int OPB_W      = 20;  // multiplier operand B (speeds, error terms)
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int FRAC_W     = 8;   // Q8.8 gains, alpha/256
  localparam int DELTA_W    = ACC_W - FRAC_W;
  localparam int SUM_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int PID_W      = 21;
  localparam int PWM_W      = 12;
  localparam int LIM_W      = 11;
  localparam int ALPHA_W    = 9;
  localparam int DB_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(128);

  localparam logic signed [GAIN_W-1:0]  KP_RST       = 16'sd256;
  localparam logic signed [GAIN_W-1:0]  KI_RST       = '0;
  localparam logic signed [GAIN_W-1:0]  KD_RST       = '0;
  localparam logic signed [PID_W-1:0]   OUT_MAX_RST  = 21'sd1920;
  localparam logic signed [PID_W-1:0]   OUT_MIN_RST  = -21'sd1920;
  localparam logic [ALPHA_W-1:0]        ALPHA_RST    = 9'd77;
  localparam logic [DB_W-1:0]           DEADBAND_RST = 16'd32;
  localparam logic [LIM_W-1:0]          PWM_LIM_RST  = 11'd1920;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP        = 3'd0,
    REG_KI        = 3'd1,
    REG_KD        = 3'd2,
    REG_OUT_MAX   = 3'd3,
    REG_OUT_MIN   = 3'd4,
    REG_ALPHA     = 3'd5,
    REG_DEADBAND  = 3'd6,
    REG_PWM_LIMIT = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_F_MUL0,
    S_F_MUL1,
    S_F_ADD,
    S_FILT,
    S_ERR,
    S_CMP,
    S_P_MUL,
    S_I_MUL,
    S_D_MUL,
    S_D_ADD,
    S_DELTA,
    S_CLAMP_PID,
    S_PWM_ADD,
    S_CLAMP_PWM,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/msipid_if.sv =====
// Valid/ready channel interfaces of the motor speed incremental PID block:
// input word, result word and config write. Depends on msipid_pkg.
interface msipid_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [msipid_pkg::SPEED_W-1:0]     measured_speed;
  logic signed [msipid_pkg::SPEED_W-1:0]     target_speed;

  modport source (output valid, measured_speed, target_speed, input ready);
  modport sink   (input valid, measured_speed, target_speed, output ready);
endinterface

interface msipid_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [msipid_pkg::PWM_W-1:0]       pwm_command;
  logic signed [msipid_pkg::SPEED_W-1:0]     filtered_speed;
  logic                                      pid_updated;

  modport source (output valid, pwm_command, filtered_speed, pid_updated, input ready);
  modport sink   (input valid, pwm_command, filtered_speed, pid_updated, output ready);
endinterface

interface msipid_cfg_if;
  logic                                      valid;
  logic                                      ready;
  logic [msipid_pkg::CFG_IDX_W-1:0]          index;
  logic [msipid_pkg::CFG_DATA_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/motor_speed_incremental_pid.sv =====
// Motor speed incremental PID: EMA speed filter, deadband, incremental PID,
// clamped PID output and saturating PWM accumulator, one shared multiplier.
// Depends on msipid_pkg, msipid_if.sv and motor_speed_incremental_pid_defines.svh.
//
//   channel  | dir | handshake         | word
//   ---------+-----+-------------------+-----------------------------------------
//   in_ch    | in  | valid/ready       | measured_speed, target_speed (Q11.4)
//   out_ch   | out | valid/ready       | pwm_command, filtered_speed, pid_updated
//   cfg_ch   | in  | valid/ready       | index (0..7), data (21 bits)
//
// One 16x20 signed multiplier is shared by all five products under a
// 16-state sequencer; when the error is inside the deadband the sequencer
// goes from S_CMP straight to S_DONE and skips the PID states.
// rst_n is synchronous, active low; it restores the register defaults and
// clears the filter, error history, PID output and PWM accumulator.
// The result sits in an output register, so a new word is taken while it
// waits; only a second finished word waits in S_DONE for out_ch.ready.
// Config writes are taken only between words (cfg_ch.ready high in S_IDLE).
`include "motor_speed_incremental_pid_defines.svh"

module motor_speed_incremental_pid (
  input  logic                clk,
  input  logic                rst_n,
  msipid_in_if.sink           in_ch,
  msipid_out_if.source        out_ch,
  msipid_cfg_if.sink          cfg_ch
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic signed [msipid_pkg::GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic signed [msipid_pkg::PID_W-1:0]  out_max_r, out_min_r;
  logic [msipid_pkg::ALPHA_W-1:0]       alpha_r;
  logic [msipid_pkg::DB_W-1:0]          deadband_r;
  logic [msipid_pkg::LIM_W-1:0]         pwm_limit_r;

  // ---------------------------------------------------------------------------
  // Sequencer, architectural state and work registers
  // ---------------------------------------------------------------------------
  msipid_pkg::state_t state_r, state_nxt;

  logic signed [msipid_pkg::SPEED_W-1:0]  prev_filt_r, prev_filt_nxt;
  logic signed [msipid_pkg::ERR_ST_W-1:0] err_last_r, err_last_nxt;
  logic signed [msipid_pkg::ERR_ST_W-1:0] err_prev_r, err_prev_nxt;
  logic signed [msipid_pkg::PID_W-1:0]    pid_r, pid_nxt;
  logic signed [msipid_pkg::PWM_W-1:0]    pwm_r, pwm_nxt;
  logic                                   run_r, run_nxt;
  logic                                   out_valid_r, out_valid_nxt;

  // payload, no reset
  logic signed [msipid_pkg::SPEED_W-1:0]  meas_r, target_r;
  logic signed [msipid_pkg::PROD_W-1:0]   prod_r;
  logic signed [msipid_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [msipid_pkg::ERR_W-1:0]    err_r, err_nxt;
  logic signed [msipid_pkg::D1_W-1:0]     d1_r, d1_nxt;
  logic signed [msipid_pkg::OPB_W-1:0]    d2_r, d2_nxt;
  logic signed [msipid_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [msipid_pkg::PWM_W-1:0]    out_pwm_r;
  logic signed [msipid_pkg::SPEED_W-1:0]  out_filt_r;
  logic                                   out_upd_r;

  // shared multiplier
  logic signed [msipid_pkg::OPA_W-1:0]    mul_a;
  logic signed [msipid_pkg::OPB_W-1:0]    mul_b;
  logic signed [msipid_pkg::PROD_W-1:0]   mul_p;

  // datapath helpers
  logic [msipid_pkg::ALPHA_W-1:0]         a_eff;
  logic signed [msipid_pkg::ACC_W-1:0]    acc_rnd;
  logic signed [msipid_pkg::DELTA_W-1:0]  delta;
  logic [msipid_pkg::ERR_W-1:0]           err_mag;
  logic signed [msipid_pkg::SUM_W-1:0]    hi_pid, lo_pid, hi_pwm, lo_pwm;
  logic signed [msipid_pkg::PWM_W-1:0]    lim_s;
  logic                                   in_acc, out_load;

  assign in_ch.ready  = (state_r == msipid_pkg::S_IDLE);
  assign cfg_ch.ready = (state_r == msipid_pkg::S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pwm_command    = out_pwm_r;
  assign out_ch.filtered_speed = out_filt_r;
  assign out_ch.pid_updated    = out_upd_r;

  // alpha above 256 acts as 256
  assign a_eff = (alpha_r > msipid_pkg::ALPHA_ONE) ? msipid_pkg::ALPHA_ONE : alpha_r;

  assign mul_p   = mul_a * mul_b;
  assign acc_rnd = acc_r + msipid_pkg::ROUND_HALF;   // floor((x+128)/256) below
  assign delta   = acc_rnd[msipid_pkg::ACC_W-1:msipid_pkg::FRAC_W];
  assign err_mag = err_r[msipid_pkg::ERR_W-1] ? (-err_r) : err_r;

  assign hi_pid = msipid_pkg::SUM_W'(out_max_r);
  assign lo_pid = msipid_pkg::SUM_W'(out_min_r);
  assign lim_s  = {1'b0, pwm_limit_r};
  assign hi_pwm = msipid_pkg::SUM_W'(lim_s);
  assign lo_pwm = -hi_pwm;

  assign out_load = (state_r == msipid_pkg::S_DONE) && (!out_valid_r || out_ch.ready);

  // ---------------------------------------------------------------------------
  // Next state, multiplier operand select, datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    prev_filt_nxt = prev_filt_r;
    err_last_nxt  = err_last_r;
    err_prev_nxt  = err_prev_r;
    pid_nxt       = pid_r;
    pwm_nxt       = pwm_r;
    run_nxt       = run_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    sum_nxt       = sum_r;
    mul_a         = kp_r;
    mul_b         = msipid_pkg::OPB_W'(d1_r);
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      msipid_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = msipid_pkg::S_F_MUL0;
        end
      end
      msipid_pkg::S_F_MUL0: begin
        mul_a     = msipid_pkg::OPA_W'(a_eff);
        mul_b     = msipid_pkg::OPB_W'(meas_r);
        state_nxt = msipid_pkg::S_F_MUL1;
      end
      msipid_pkg::S_F_MUL1: begin
        acc_nxt   = msipid_pkg::ACC_W'(prod_r);
        mul_a     = msipid_pkg::OPA_W'(msipid_pkg::ALPHA_ONE - a_eff);
        mul_b     = msipid_pkg::OPB_W'(prev_filt_r);
        state_nxt = msipid_pkg::S_F_ADD;
      end
      msipid_pkg::S_F_ADD: begin
        acc_nxt   = acc_r + msipid_pkg::ACC_W'(prod_r);
        state_nxt = msipid_pkg::S_FILT;
      end
      msipid_pkg::S_FILT: begin
        // convex combination, always fits the speed width
        prev_filt_nxt = acc_rnd[msipid_pkg::SPEED_W+msipid_pkg::FRAC_W-1:msipid_pkg::FRAC_W];
        state_nxt     = msipid_pkg::S_ERR;
      end
      msipid_pkg::S_ERR: begin
        err_nxt   = msipid_pkg::ERR_W'(target_r) - msipid_pkg::ERR_W'(prev_filt_r);
        state_nxt = msipid_pkg::S_CMP;
      end
      msipid_pkg::S_CMP: begin
        run_nxt = (err_mag > msipid_pkg::ERR_W'(deadband_r));
        d1_nxt  = msipid_pkg::D1_W'(err_r) - msipid_pkg::D1_W'(err_last_r);
        d2_nxt  = msipid_pkg::OPB_W'(err_r)
                - (msipid_pkg::OPB_W'(err_last_r) <<< 1)
                + msipid_pkg::OPB_W'(err_prev_r);
        state_nxt = run_nxt ? msipid_pkg::S_P_MUL : msipid_pkg::S_DONE;
      end
      msipid_pkg::S_P_MUL: begin
        mul_a     = kp_r;
        mul_b     = msipid_pkg::OPB_W'(d1_r);
        state_nxt = msipid_pkg::S_I_MUL;
      end
      msipid_pkg::S_I_MUL: begin
        acc_nxt   = msipid_pkg::ACC_W'(prod_r);
        mul_a     = ki_r;
        mul_b     = msipid_pkg::OPB_W'(err_r);
        state_nxt = msipid_pkg::S_D_MUL;
      end
      msipid_pkg::S_D_MUL: begin
        acc_nxt   = acc_r + msipid_pkg::ACC_W'(prod_r);
        mul_a     = kd_r;
        mul_b     = d2_r;
        state_nxt = msipid_pkg::S_D_ADD;
      end
      msipid_pkg::S_D_ADD: begin
        acc_nxt   = acc_r + msipid_pkg::ACC_W'(prod_r);
        state_nxt = msipid_pkg::S_DELTA;
      end
      msipid_pkg::S_DELTA: begin
        sum_nxt      = msipid_pkg::SUM_W'(pid_r) + msipid_pkg::SUM_W'(delta);
        err_prev_nxt = err_last_r;
        err_last_nxt = msipid_pkg::ERR_ST_W'(err_r);
        state_nxt    = msipid_pkg::S_CLAMP_PID;
      end
      msipid_pkg::S_CLAMP_PID: begin
        // upper bound is checked first; crossed bounds give out_max above it, else out_min
        priority if (sum_r > hi_pid) begin
          pid_nxt = out_max_r;
        end else if (sum_r < lo_pid) begin
          pid_nxt = out_min_r;
        end else begin
          pid_nxt = sum_r[msipid_pkg::PID_W-1:0];
        end
        state_nxt = msipid_pkg::S_PWM_ADD;
      end
      msipid_pkg::S_PWM_ADD: begin
        sum_nxt   = msipid_pkg::SUM_W'(pwm_r) + msipid_pkg::SUM_W'(pid_r);
        state_nxt = msipid_pkg::S_CLAMP_PWM;
      end
      msipid_pkg::S_CLAMP_PWM: begin
        priority if (sum_r > hi_pwm) begin
          pwm_nxt = lim_s;
        end else if (sum_r < lo_pwm) begin
          pwm_nxt = -lim_s;
        end else begin
          pwm_nxt = sum_r[msipid_pkg::PWM_W-1:0];
        end
        state_nxt = msipid_pkg::S_DONE;
      end
      msipid_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = msipid_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = msipid_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers with reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msipid_pkg::S_IDLE;
      prev_filt_r <= '0;
      err_last_r  <= '0;
      err_prev_r  <= '0;
      pid_r       <= '0;
      pwm_r       <= '0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_filt_r <= prev_filt_nxt;
      err_last_r  <= err_last_nxt;
      err_prev_r  <= err_prev_nxt;
      pid_r       <= pid_nxt;
      pwm_r       <= pwm_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= msipid_pkg::KP_RST;
      ki_r        <= msipid_pkg::KI_RST;
      kd_r        <= msipid_pkg::KD_RST;
      out_max_r   <= msipid_pkg::OUT_MAX_RST;
      out_min_r   <= msipid_pkg::OUT_MIN_RST;
      alpha_r     <= msipid_pkg::ALPHA_RST;
      deadband_r  <= msipid_pkg::DEADBAND_RST;
      pwm_limit_r <= msipid_pkg::PWM_LIM_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (msipid_pkg::cfg_reg_t'(cfg_ch.index))
        msipid_pkg::REG_KP:        kp_r        <= cfg_ch.data[msipid_pkg::GAIN_W-1:0];
        msipid_pkg::REG_KI:        ki_r        <= cfg_ch.data[msipid_pkg::GAIN_W-1:0];
        msipid_pkg::REG_KD:        kd_r        <= cfg_ch.data[msipid_pkg::GAIN_W-1:0];
        msipid_pkg::REG_OUT_MAX:   out_max_r   <= cfg_ch.data[msipid_pkg::PID_W-1:0];
        msipid_pkg::REG_OUT_MIN:   out_min_r   <= cfg_ch.data[msipid_pkg::PID_W-1:0];
        msipid_pkg::REG_ALPHA:     alpha_r     <= cfg_ch.data[msipid_pkg::ALPHA_W-1:0];
        msipid_pkg::REG_DEADBAND:  deadband_r  <= cfg_ch.data[msipid_pkg::DB_W-1:0];
        msipid_pkg::REG_PWM_LIMIT: pwm_limit_r <= cfg_ch.data[msipid_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r   <= in_ch.measured_speed;
      target_r <= in_ch.target_speed;
    end
    prod_r <= mul_p;
    acc_r  <= acc_nxt;
    err_r  <= err_nxt;
    d1_r   <= d1_nxt;
    d2_r   <= d2_nxt;
    sum_r  <= sum_nxt;
    if (out_load) begin
      out_pwm_r  <= pwm_r;
      out_filt_r <= prev_filt_r;
      out_upd_r  <= run_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `MSIPID_ASSERT(a_accept_starts_filter,
    (in_ch.valid && in_ch.ready) |=> (state_r == msipid_pkg::S_F_MUL0))
  `MSIPID_ASSERT(a_pwm_within_limit,
    ($past(state_r) == msipid_pkg::S_CLAMP_PWM) |-> ((pwm_r <= lim_s) && (pwm_r >= -lim_s)))
  `MSIPID_ASSERT(a_pid_within_bounds,
    (($past(state_r) == msipid_pkg::S_CLAMP_PID) && (out_min_r <= out_max_r))
      |-> ((pid_r <= out_max_r) && (pid_r >= out_min_r)))
  `MSIPID_ASSERT(a_done_loads_output,
    ((state_r == msipid_pkg::S_DONE) && !out_valid_r) |=> out_valid_r)

endmodule
